@@ hw/rtl/psq_pkg.sv @@
package psq_pkg;

    localparam int FRAC_BITS = 16;

    localparam int HZ_W     = 32;
    localparam int A4_W     = 26;
    localparam int MASK_W   = 12;
    localparam int LEAD_W   = 5;
    localparam int LOG_W    = LEAD_W + FRAC_BITS;
    localparam int MIDI_W   = FRAC_BITS + 11;
    localparam int N_W      = 10;
    localparam int OCT_W    = 6;
    localparam int PC_W     = FRAC_BITS + 4;
    localparam int TAB_W    = 17;
    localparam int PROD_W   = A4_W + TAB_W;
    localparam int CNT_W    = $clog2(FRAC_BITS);
    localparam int SHIFT_W  = 7;
    localparam int TARGET_W = 10;

    localparam logic [7:0]           OCT_RECIP    = 8'd171;
    localparam int                   OCT_RECIP_SH = 11;
    localparam logic [3:0]           SEMIS        = 4'd12;
    localparam logic [3:0]           LAST_SEMI    = 4'd11;
    localparam logic [4:0]           NOTE_OFFSET  = 5'd3;
    localparam logic [SHIFT_W-1:0]   SHIFT_BIAS   = 7'd22;
    localparam logic signed [MIDI_W-1:0] MIDI_A4  = MIDI_W'(69) <<< FRAC_BITS;

    localparam logic [A4_W-1:0]   A4_RESET   = 26'd28835840;
    localparam logic [MASK_W-1:0] MASK_RESET = 12'd4095;

    localparam logic REG_A4   = 1'b0;
    localparam logic REG_MASK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOGA,
        ST_LOGH,
        ST_MIDI,
        ST_OCT,
        ST_PC,
        ST_SCAN,
        ST_NOTE,
        ST_PROD,
        ST_SHIFT
    } state_t;

    function automatic logic [LEAD_W-1:0] lead_one(input logic [HZ_W-1:0] x);
        logic [LEAD_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < HZ_W; i++) begin
            if (x[i])
            begin
                pos = LEAD_W'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [TAB_W-1:0] semitone(input logic [3:0] r);
        logic [TAB_W-1:0] v;
        unique case (r)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd69433;
            4'd2:    v = 17'd73562;
            4'd3:    v = 17'd77936;
            4'd4:    v = 17'd82570;
            4'd5:    v = 17'd87480;
            4'd6:    v = 17'd92682;
            4'd7:    v = 17'd98193;
            4'd8:    v = 17'd104032;
            4'd9:    v = 17'd110218;
            4'd10:   v = 17'd116772;
            4'd11:   v = 17'd123715;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/pitch_scale_quantizer.sv @@
// A zero input or a zero a4_hz is passed through without the log2; an input below note 0 is passed through after it.
// On the first beat after reset or after an a4_hz write, the reference log2 is rebuilt first.
// A new beat is taken only when the last one is through; busy is high meanwhile.
// Each log2 is 16 squaring steps on the shared 32x32 multiplier; the scale scan has 11 steps.
// Reset (rst_n, asynchronous, active low) restores a4_hz = 440 Hz and the full scale mask.
// The receiver cannot stall: each result beat is on the ports for one cycle with done high.
module pitch_scale_quantizer
    import psq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [HZ_W-1:0]     hz_in,
    output logic                busy,
    output logic                done,
    output logic [HZ_W-1:0]     out_hz,
    output logic [7:0]          note,
    output logic                passed_through,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    state_t state_reg, state_next;

    logic [A4_W-1:0]          a4_reg;
    logic [MASK_W-1:0]        mask_reg;
    logic                     loga_valid_reg, loga_valid_next;
    logic [LOG_W-1:0]         loga_reg, loga_next;
    logic [HZ_W-1:0]          hz_reg, hz_next;
    logic [HZ_W-1:0]          m_reg, m_next;
    logic [LEAD_W-1:0]        lead_reg, lead_next;
    logic [FRAC_BITS-1:0]     frac_reg, frac_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [MIDI_W-1:0] midi_reg, midi_next;
    logic [OCT_W-1:0]         oct_reg, oct_next;
    logic [PC_W-1:0]          pc_reg, pc_next;
    logic [3:0]               k_reg, k_next;
    logic [3:0]               best_reg, best_next;
    logic [PC_W-1:0]          best_dist_reg, best_dist_next;
    logic [3:0]               r_reg, r_next;
    logic signed [SHIFT_W-1:0] s_reg, s_next;
    logic [TARGET_W-1:0]      target_reg, target_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic                     done_reg, done_next;
    logic [HZ_W-1:0]          out_hz_reg, out_hz_next;
    logic [7:0]               note_reg, note_next;
    logic                     pass_reg, pass_next;

    logic                     cfg_wr;
    logic [HZ_W-1:0]          norm_src;
    logic [LEAD_W-1:0]        norm_lead;
    logic [HZ_W-1:0]          norm_m;
    logic [HZ_W-1:0]          mul_a, mul_b;
    logic [2*HZ_W-1:0]        mul_p;
    logic [HZ_W:0]            sq_t;
    logic                     sq_bit;
    logic [HZ_W-1:0]          m_step;
    logic [FRAC_BITS-1:0]     frac_step;
    logic                     log_last;
    logic signed [LOG_W:0]    d;
    logic signed [MIDI_W-1:0] d_ext;
    logic [N_W-1:0]           n_val;
    logic [N_W+7:0]           oct_prod;
    logic [TARGET_W-1:0]      oct12;
    logic [MIDI_W-1:0]        oct_off;
    logic signed [MIDI_W-1:0] pc_full;
    logic [PC_W-1:0]          kf;
    logic signed [PC_W:0]     kdiff;
    logic [PC_W-1:0]          k_dist;
    logic [4:0]               rsum;
    logic                     wrap;
    logic [2*HZ_W-1:0]        prod_ext;
    logic [2*HZ_W-1:0]        shifted;
    logic [SHIFT_W-1:0]       neg_s;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign busy   = (state_reg != ST_IDLE);

    assign done           = done_reg;
    assign out_hz         = out_hz_reg;
    assign note           = note_reg;
    assign passed_through = pass_reg;

    always_comb
    begin
        unique case (paddr[2])
            REG_A4:   prdata = {{(32-A4_W){1'b0}}, a4_reg};
            REG_MASK: prdata = {{(32-MASK_W){1'b0}}, mask_reg};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a4_reg   <= A4_RESET;
            mask_reg <= MASK_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_A4:   a4_reg   <= pwdata[A4_W-1:0];
                REG_MASK: mask_reg <= pwdata[MASK_W-1:0];
                default:  ;
            endcase
        end
    end

    // shared multiplier: squaring in log2, a4 times semitone ratio later
    always_comb
    begin
        unique case (state_reg)
            ST_LOGA, ST_LOGH:
            begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            ST_PROD:
            begin
                mul_a = {{(HZ_W-A4_W){1'b0}}, a4_reg};
                mul_b = {{(HZ_W-TAB_W){1'b0}}, semitone(r_reg)};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign sq_t      = mul_p[2*HZ_W-1:HZ_W-1];
    assign sq_bit    = sq_t[HZ_W];
    assign m_step    = sq_bit ? sq_t[HZ_W:1] : sq_t[HZ_W-1:0];
    assign frac_step = {frac_reg[FRAC_BITS-2:0], sq_bit};
    assign log_last  = (cnt_reg == CNT_W'(FRAC_BITS - 1));

    always_comb
    begin
        priority if (state_reg == ST_IDLE && !loga_valid_reg)
        begin
            norm_src = {{(HZ_W-A4_W){1'b0}}, a4_reg};
        end
        else if (state_reg == ST_IDLE)
        begin
            norm_src = hz_in;
        end
        else
        begin
            norm_src = hz_reg;
        end
    end

    assign norm_lead = lead_one(norm_src);
    assign norm_m    = norm_src << (LEAD_W'(HZ_W - 1) - norm_lead);

    assign d        = $signed({1'b0, lead_reg, frac_reg}) - $signed({1'b0, loga_reg});
    assign d_ext    = {{(MIDI_W-LOG_W-1){d[LOG_W]}}, d};
    assign n_val    = midi_reg[FRAC_BITS+N_W-1:FRAC_BITS];
    assign oct_prod = n_val * OCT_RECIP;
    assign oct12    = TARGET_W'(oct_reg * SEMIS);
    assign oct_off  = MIDI_W'(oct12) << FRAC_BITS;
    assign pc_full  = midi_reg - $signed(oct_off);

    assign kf     = {k_reg, {FRAC_BITS{1'b0}}};
    assign kdiff  = $signed({1'b0, pc_reg}) - $signed({1'b0, kf});
    assign k_dist = kdiff[PC_W] ? PC_W'(-kdiff) : kdiff[PC_W-1:0];

    assign rsum = {1'b0, best_reg} + NOTE_OFFSET;
    assign wrap = (rsum >= {1'b0, SEMIS});

    assign prod_ext = {{(2*HZ_W-PROD_W){1'b0}}, prod_reg};
    assign neg_s    = SHIFT_W'(-s_reg);
    assign shifted  = s_reg[SHIFT_W-1] ? (prod_ext >> neg_s[4:0]) : (prod_ext << s_reg[4:0]);

    always_comb
    begin
        state_next      = state_reg;
        loga_valid_next = loga_valid_reg;
        loga_next       = loga_reg;
        hz_next         = hz_reg;
        m_next          = m_reg;
        lead_next       = lead_reg;
        frac_next       = frac_reg;
        cnt_next        = cnt_reg;
        midi_next       = midi_reg;
        oct_next        = oct_reg;
        pc_next         = pc_reg;
        k_next          = k_reg;
        best_next       = best_reg;
        best_dist_next  = best_dist_reg;
        r_next          = r_reg;
        s_next          = s_reg;
        target_next     = target_reg;
        prod_next       = prod_reg;
        done_next       = 1'b0;
        out_hz_next     = out_hz_reg;
        note_next       = note_reg;
        pass_next       = pass_reg;

        if (cfg_wr && paddr[2] == REG_A4)
        begin
            loga_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    hz_next   = hz_in;
                    m_next    = norm_m;
                    lead_next = norm_lead;
                    cnt_next  = '0;
                    priority if (hz_in == '0 || a4_reg == '0)
                    begin
                        done_next   = 1'b1;
                        out_hz_next = hz_in;
                        note_next   = '0;
                        pass_next   = 1'b1;
                    end
                    else if (!loga_valid_reg)
                    begin
                        state_next = ST_LOGA;
                    end
                    else
                    begin
                        state_next = ST_LOGH;
                    end
                end
            end

            ST_LOGA:
            begin
                m_next    = m_step;
                frac_next = frac_step;
                cnt_next  = cnt_reg + 1'b1;
                if (log_last)
                begin
                    loga_next       = {lead_reg, frac_step};
                    loga_valid_next = 1'b1;
                    m_next          = norm_m;
                    lead_next       = norm_lead;
                    cnt_next        = '0;
                    state_next      = ST_LOGH;
                end
            end

            ST_LOGH:
            begin
                m_next    = m_step;
                frac_next = frac_step;
                cnt_next  = cnt_reg + 1'b1;
                if (log_last)
                begin
                    state_next = ST_MIDI;
                end
            end

            ST_MIDI:
            begin
                midi_next  = MIDI_A4 + (d_ext <<< 3) + (d_ext <<< 2);
                state_next = ST_OCT;
            end

            ST_OCT:
            begin
                oct_next = oct_prod[OCT_RECIP_SH+OCT_W-1:OCT_RECIP_SH];
                if (midi_reg[MIDI_W-1])
                begin
                    done_next   = 1'b1;
                    out_hz_next = hz_reg;
                    note_next   = '0;
                    pass_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_PC;
                end
            end

            ST_PC:
            begin
                pc_next        = pc_full[PC_W-1:0];
                best_dist_next = pc_full[PC_W-1:0];
                best_next      = '0;
                k_next         = 4'd1;
                state_next     = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (mask_reg[k_reg])
                begin
                    priority if (!mask_reg[0] && best_reg == '0)
                    begin
                        best_next      = k_reg;
                        best_dist_next = k_dist;
                    end
                    else if (k_dist < best_dist_reg)
                    begin
                        best_next      = k_reg;
                        best_dist_next = k_dist;
                    end
                    else
                    begin
                        best_next = best_reg;
                    end
                end
                k_next = k_reg + 1'b1;
                if (k_reg == LAST_SEMI)
                begin
                    state_next = ST_NOTE;
                end
            end

            ST_NOTE:
            begin
                r_next      = wrap ? 4'(rsum - {1'b0, SEMIS}) : rsum[3:0];
                s_next      = $signed({1'b0, oct_reg}) + $signed({6'b0, wrap})
                              - $signed(SHIFT_BIAS);
                target_next = oct12 + {{(TARGET_W-4){1'b0}}, best_reg};
                state_next  = ST_PROD;
            end

            ST_PROD:
            begin
                prod_next  = mul_p[PROD_W-1:0];
                state_next = ST_SHIFT;
            end

            ST_SHIFT:
            begin
                done_next   = 1'b1;
                out_hz_next = (shifted[2*HZ_W-1:HZ_W] != '0) ? '1 : shifted[HZ_W-1:0];
                note_next   = (target_reg > TARGET_W'(255)) ? 8'd255 : target_reg[7:0];
                pass_next   = 1'b0;
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            loga_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            k_reg          <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            loga_valid_reg <= loga_valid_next;
            cnt_reg        <= cnt_next;
            k_reg          <= k_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        loga_reg      <= loga_next;
        hz_reg        <= hz_next;
        m_reg         <= m_next;
        lead_reg      <= lead_next;
        frac_reg      <= frac_next;
        midi_reg      <= midi_next;
        oct_reg       <= oct_next;
        pc_reg        <= pc_next;
        best_reg      <= best_next;
        best_dist_reg <= best_dist_next;
        r_reg         <= r_next;
        s_reg         <= s_next;
        target_reg    <= target_next;
        prod_reg      <= prod_next;
        out_hz_reg    <= out_hz_next;
        note_reg      <= note_next;
        pass_reg      <= pass_next;
    end

endmodule
